// ----- rtl/pfa_pkg.sv -----
`default_nettype none
package pfa_pkg;

  // Default frame count of the managed memory
  localparam int FRAMES_DEF = 65536;

  // Page geometry
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int PFN_W      = ADDR_W - PAGE_SHIFT;

  // Stream payload widths (fields packed from bit 0, padded to bytes)
  localparam int IN_W  = 104;
  localparam int OUT_W = 104;

  // Configuration register indexes
  localparam logic [1:0] REG_GUARD = 2'd0;
  localparam logic [1:0] REG_LOW   = 2'd1;
  localparam logic [1:0] REG_HIGH  = 2'd2;
  localparam int CFG_W = 17;

  // Request codes
  localparam logic [1:0] ACT_FREE  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_ADDR = 2'd1;
  localparam logic [1:0] STAT_DBL_FREE = 2'd2;
  localparam logic [1:0] STAT_NO_MEM   = 2'd3;

  // One frame table entry
  typedef struct packed {
    logic        alloc;
    logic [31:0] owner;
    logic [31:0] tick;
  } entry_t;

  localparam entry_t ENTRY_FREE = '{alloc: 1'b0, owner: 32'hFFFF_FFFF, tick: 32'h0};

  localparam logic [16:0] HIGH_RESET = 17'h10000;

endpackage
`default_nettype wire

// ----- rtl/page_frame_allocator.sv -----
`default_nettype none
// Page-frame allocator: LIFO free stack plus a per-frame table (allocated
// flag, owner id, start tick), both held in synchronous single-port memories.
// Requests arrive on the s_axis channel (free, allocate, read entry); every
// request yields exactly one result transfer on m_axis.
// A request is accepted in ST_IDLE, which issues the memory reads; ST_EXEC
// then does the check, the write-back and loads the output register. Due to
// the read-modify-write of the frame table and stack, a new request is only
// taken once the previous one has left ST_EXEC. The output register lets a
// request be accepted while the previous result waits; if the result is
// still not taken when the next one is done, the block holds in ST_EXEC.
// After reset the frame table is swept to free/owner -1/tick 0, one entry per
// cycle, over all FRAMES entries; s_axis_tready stays low during the sweep,
// while configuration writes are taken at any time. The free count restarts
// at 0. Configuration: cfg_we with cfg_index 0 guard_enable, 1 low_frame,
// 2 high_frame; write only while no request is in flight.
module page_frame_allocator #(
  parameter int FRAMES = pfa_pkg::FRAMES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // tdata: action[1:0], page_addr[33:2], owner_pid[65:34], now_tick[97:66]
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [pfa_pkg::IN_W-1:0]   s_axis_tdata,
  // tdata: status[1:0], alloc_addr[33:2], entry_allocated[34],
  //        entry_owner[66:35], entry_tick[98:67]
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [pfa_pkg::OUT_W-1:0]       m_axis_tdata,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [pfa_pkg::CFG_W-1:0]  cfg_data
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int PW = pfa_pkg::PFN_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  // Memories
  pfa_pkg::entry_t tbl_mem [FRAMES];
  logic [FW-1:0]   stk_mem [FRAMES];

  // Control and configuration registers
  logic [1:0]    state;
  logic [FW-1:0] clr_addr;
  logic [CW-1:0] free_count;
  logic          guard_enable;
  logic [15:0]   low_frame;
  logic [16:0]   high_frame;

  // Request captured at accept
  logic [1:0]    req_act;
  logic [FW-1:0] req_frame;
  logic          req_bad;
  logic          req_empty;
  logic [31:0]   req_owner;
  logic [31:0]   req_tick;

  // Memory read data
  pfa_pkg::entry_t tbl_rd;
  logic [FW-1:0]   stk_rd;

  // Output register fields
  logic [1:0]  o_status;
  logic [31:0] o_addr;
  logic        o_alloc;
  logic [31:0] o_owner;
  logic [31:0] o_tick;

  // Input field decode
  logic [1:0]    in_act;
  logic [31:0]   in_addr;
  logic [PW-1:0] in_pfn;
  logic          in_range;
  logic          in_free_ok;
  logic          accept;
  logic          out_free;
  logic          exec_go;
  logic [CW-1:0] cnt_dec;

  assign in_act   = s_axis_tdata[1:0];
  assign in_addr  = s_axis_tdata[33:2];
  assign in_pfn   = in_addr[31:pfa_pkg::PAGE_SHIFT];
  assign in_range = ({1'b0, in_pfn} < (PW + 1)'(FRAMES));
  assign in_free_ok = (in_addr[pfa_pkg::PAGE_SHIFT-1:0] == '0) && in_range
                    && (in_pfn >= PW'(low_frame)) && (in_pfn < PW'(high_frame));

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign exec_go       = (state == ST_EXEC) && out_free;
  assign cnt_dec       = free_count - CW'(1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      guard_enable <= 1'b0;
      low_frame    <= '0;
      high_frame   <= pfa_pkg::HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pfa_pkg::REG_GUARD: guard_enable <= cfg_data[0];
        pfa_pkg::REG_LOW:   low_frame    <= cfg_data[15:0];
        pfa_pkg::REG_HIGH:  high_frame   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Capture the request at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      req_act   <= in_act;
      req_frame <= in_pfn[FW-1:0];
      req_bad   <= (in_act == pfa_pkg::ACT_FREE) ? !in_free_ok : !in_range;
      req_empty <= (free_count == '0);
      req_owner <= s_axis_tdata[65:34];
      req_tick  <= s_axis_tdata[97:66];
    end
  end

  // Memory reads, issued only at accept so the data holds while stalled
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      tbl_rd <= tbl_mem[in_pfn[FW-1:0]];
    end
    if (accept && (free_count != '0)) begin
      stk_rd <= stk_mem[cnt_dec[FW-1:0]];
    end
  end

  // Write-back decisions
  logic            tbl_we;
  logic [FW-1:0]   tbl_waddr;
  pfa_pkg::entry_t tbl_wdata;
  logic            stk_we;
  logic            do_free;
  logic            do_alloc;

  always_comb begin
    do_free  = exec_go && (req_act == pfa_pkg::ACT_FREE) && !req_bad
             && !(guard_enable && !tbl_rd.alloc);
    do_alloc = exec_go && (req_act == pfa_pkg::ACT_ALLOC) && !req_empty;
    stk_we   = do_free && (free_count != CW'(FRAMES));
    tbl_we    = 1'b0;
    tbl_waddr = req_frame;
    tbl_wdata = pfa_pkg::ENTRY_FREE;
    if (state == ST_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_addr;
    end else if (do_free) begin
      tbl_we = 1'b1;
    end else if (do_alloc) begin
      tbl_we          = 1'b1;
      tbl_waddr       = stk_rd;
      tbl_wdata.alloc = 1'b1;
      tbl_wdata.owner = guard_enable ? req_owner : 32'hFFFF_FFFF;
      tbl_wdata.tick  = guard_enable ? req_tick : 32'h0;
    end
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (stk_we) begin
      stk_mem[free_count[FW-1:0]] <= req_frame;
    end
  end

  // Sequencer, clear sweep and free count
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      free_count <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + FW'(1);
          if (clr_addr == FW'(FRAMES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
          if (stk_we) begin
            free_count <= free_count + CW'(1);
          end else if (do_alloc) begin
            free_count <= cnt_dec;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (exec_go) begin
      o_status <= pfa_pkg::STAT_OK;
      o_addr   <= '0;
      o_alloc  <= 1'b0;
      o_owner  <= '0;
      o_tick   <= '0;
      case (req_act)
        pfa_pkg::ACT_FREE: begin
          if (req_bad) begin
            o_status <= pfa_pkg::STAT_BAD_ADDR;
          end else if (guard_enable && !tbl_rd.alloc) begin
            o_status <= pfa_pkg::STAT_DBL_FREE;
          end
        end
        pfa_pkg::ACT_ALLOC: begin
          if (req_empty) begin
            o_status <= pfa_pkg::STAT_NO_MEM;
          end else begin
            o_addr <= 32'(stk_rd) << pfa_pkg::PAGE_SHIFT;
          end
        end
        pfa_pkg::ACT_READ: begin
          if (req_bad) begin
            o_status <= pfa_pkg::STAT_BAD_ADDR;
          end else begin
            o_alloc <= tbl_rd.alloc;
            o_owner <= tbl_rd.owner;
            o_tick  <= tbl_rd.tick;
          end
        end
        default: ;
      endcase
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (exec_go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {5'b0, o_tick, o_owner, o_alloc, o_addr, o_status};

endmodule
`default_nettype wire
